>>> rtl/core/aat_pkg.sv
// aat_pkg: widths, payload types, register codes and helpers for the box transform.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none

package aat_pkg;

    // Field widths and fixed-point layout
    localparam int COORD_W    = 32;   // Q16.16 coordinates
    localparam int COEFF_W    = 16;   // signed coefficient bits used per lane
    localparam int COEFF_FRAC = 12;   // Q4.12
    localparam int LANE_W     = 16;   // lane pitch in the row registers
    localparam int N_AXES     = 3;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int SHIFT_W    = 32;   // stored width of a translation register

    localparam int PROD_W = COORD_W + COEFF_W;
    localparam int SHF_W  = COORD_W + COEFF_FRAC;
    localparam int SUM_W  = ((PROD_W > SHF_W) ? PROD_W : SHF_W) + 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEFF_W-1:0] t_coeff;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;

    // Register indexes on the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X   = 3'd0,
        REG_ROW_Y   = 3'd1,
        REG_ROW_Z   = 3'd2,
        REG_SHIFT_X = 3'd3,
        REG_SHIFT_Y = 3'd4,
        REG_SHIFT_Z = 3'd5
    } t_cfg_reg;

    // Coefficients indexed [output row][input lane]
    typedef t_coeff [N_AXES-1:0][N_AXES-1:0] t_coef_set;
    typedef t_coord [N_AXES-1:0]             t_shift_set;

    typedef struct packed {
        t_coord [N_AXES-1:0] lo;
        t_coord [N_AXES-1:0] hi;
        logic                empty;
    } t_box;

    typedef struct packed {
        t_prod [N_AXES-1:0][N_AXES-1:0] lo_p;
        t_prod [N_AXES-1:0][N_AXES-1:0] hi_p;
        logic                           empty;
    } t_prods;

    typedef struct packed {
        t_sum [N_AXES-1:0] min_s;
        t_sum [N_AXES-1:0] max_s;
        logic              empty;
    } t_sums;

    typedef struct packed {
        t_coord [N_AXES-1:0] min_c;
        t_coord [N_AXES-1:0] max_c;
        logic                empty;
    } t_result;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam t_coeff COEFF_ONE = COEFF_W'(64'd1 << COEFF_FRAC);

    // Stored translation bits read as a coordinate (zero-extend or truncate)
    function automatic t_coord shift_to_coord(input logic [SHIFT_W-1:0] v);
        logic [COORD_W+SHIFT_W-1:0] tmp;
        tmp = {{COORD_W{1'b0}}, v};
        return tmp[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/aat_mult_stage.sv
// aat_mult_stage: all corner products coefficient x lo/hi, one register stage.
// Depends on aat_pkg.
`default_nettype none

module aat_mult_stage import aat_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_box      i_box,
    input  t_coef_set i_coef,
    output logic      o_valid,
    input  logic      i_ready,
    output t_prods    o_prods
);

    logic   r_valid;
    t_prods r_prods;
    t_prods n_prods;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_prods = r_prods;

    // 2 x 3 x 3 independent 16x32 multipliers
    always_comb begin
        n_prods.empty = i_box.empty;
        for (int r = 0; r < N_AXES; r++) begin
            for (int a = 0; a < N_AXES; a++) begin
                n_prods.lo_p[r][a] = $signed(i_coef[r][a]) * $signed(i_box.lo[a]);
                n_prods.hi_p[r][a] = $signed(i_coef[r][a]) * $signed(i_box.hi[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prods <= n_prods;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/aat_bound_stage.sv
// aat_bound_stage: per output axis, picks smaller/larger product per lane and sums
// them with the translation and the rounding half. Depends on aat_pkg.
`default_nettype none

module aat_bound_stage import aat_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_prods     i_prods,
    input  t_shift_set i_shift,
    output logic       o_valid,
    input  logic       i_ready,
    output t_sums      o_sums
);

    localparam t_sum ROUND_HALF = SUM_W'(64'd1 << (COEFF_FRAC - 1));

    logic  r_valid;
    t_sums r_sums;
    t_sums n_sums;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_sums  = r_sums;

    always_comb begin
        t_sum  acc_min;
        t_sum  acc_max;
        t_sum  base;
        t_prod p0;
        t_prod p1;
        t_prod p_min;
        t_prod p_max;
        n_sums.empty = i_prods.empty;
        for (int r = 0; r < N_AXES; r++) begin
            // translation scaled to 2^-28 units
            base = {{(SUM_W-SHF_W){i_shift[r][COORD_W-1]}}, i_shift[r],
                    {COEFF_FRAC{1'b0}}};
            acc_min = base + ROUND_HALF;
            acc_max = base + ROUND_HALF;
            for (int a = 0; a < N_AXES; a++) begin
                p0    = i_prods.lo_p[r][a];
                p1    = i_prods.hi_p[r][a];
                p_min = (p0 < p1) ? p0 : p1;
                p_max = (p0 < p1) ? p1 : p0;
                acc_min = acc_min + {{(SUM_W-PROD_W){p_min[PROD_W-1]}}, p_min};
                acc_max = acc_max + {{(SUM_W-PROD_W){p_max[PROD_W-1]}}, p_max};
            end
            n_sums.min_s[r] = acc_min;
            n_sums.max_s[r] = acc_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sums <= n_sums;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/aat_round_stage.sv
// aat_round_stage: floor shift to Q16.16, saturation, empty-box override; holds
// the output register. Depends on aat_pkg.
`default_nettype none

module aat_round_stage import aat_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_sums   i_sums,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam t_sum SAT_HI = {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam t_sum SAT_LO = ~SAT_HI;

    logic    r_valid;
    t_result r_result;
    t_result n_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    function automatic t_coord round_sat(input t_sum s);
        t_sum q;
        q = s >>> COEFF_FRAC;
        if (q > SAT_HI) begin
            return COORD_MAX;
        end else if (q < SAT_LO) begin
            return COORD_MIN;
        end
        return q[COORD_W-1:0];
    endfunction

    always_comb begin
        n_result.empty = i_sums.empty;
        for (int r = 0; r < N_AXES; r++) begin
            if (i_sums.empty) begin
                n_result.min_c[r] = COORD_MAX;
                n_result.max_c[r] = COORD_MIN;
            end else begin
                n_result.min_c[r] = round_sat(i_sums.min_s[r]);
                n_result.max_c[r] = round_sat(i_sums.max_s[r]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/aabb_affine_transform.sv
// aabb_affine_transform: top level of the axis-aligned box affine transform.
// Depends on aat_pkg, aat_mult_stage, aat_bound_stage, aat_round_stage.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+---------------------------------
//  box     | in        | i_box_valid / o_box_ready  | min/max corner, Q16.16 x 6
//  out     | out       | o_out_valid / i_out_ready  | bounds Q16.16 x 6, empty flag
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | register index, 48-bit data
//
// One box word per cycle sustained while the output is not stalled; o_out_valid rises
// when the word reaches the output register, after the input, product and sum registers.
// Each stage advances when it is empty or the next one takes its word, so a
// stall at the output fills bubbles first and then backs up to o_box_ready.
// Reset clears all valid bits and loads the identity transform, zero shift.
// cfg is always ready; writes are expected only while the pipeline is empty.
`default_nettype none

module aabb_affine_transform import aat_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // box input channel
    input  logic                  i_box_valid,
    output logic                  o_box_ready,
    input  logic signed [COORD_W-1:0] i_box_min_x,
    input  logic signed [COORD_W-1:0] i_box_min_y,
    input  logic signed [COORD_W-1:0] i_box_min_z,
    input  logic signed [COORD_W-1:0] i_box_max_x,
    input  logic signed [COORD_W-1:0] i_box_max_y,
    input  logic signed [COORD_W-1:0] i_box_max_z,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [COORD_W-1:0] o_out_min_x,
    output logic signed [COORD_W-1:0] o_out_min_y,
    output logic signed [COORD_W-1:0] o_out_min_z,
    output logic signed [COORD_W-1:0] o_out_max_x,
    output logic signed [COORD_W-1:0] o_out_max_y,
    output logic signed [COORD_W-1:0] o_out_max_z,
    output logic                  o_box_empty,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // ---------------- configuration registers ----------------
    t_coef_set          r_coef;
    logic [SHIFT_W-1:0] r_shift [N_AXES];
    t_shift_set         shift_set;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < N_AXES; r++) begin
                for (int a = 0; a < N_AXES; a++) begin
                    r_coef[r][a] <= (r == a) ? COEFF_ONE : '0;
                end
                r_shift[r] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_ROW_X, REG_ROW_Y, REG_ROW_Z: begin
                    // only the low COEFF_W bits of each 16-bit lane are kept
                    for (int a = 0; a < N_AXES; a++) begin
                        r_coef[i_cfg_index[1:0]][a] <= i_cfg_data[a*LANE_W +: COEFF_W];
                    end
                end
                REG_SHIFT_X: r_shift[0] <= i_cfg_data[SHIFT_W-1:0];
                REG_SHIFT_Y: r_shift[1] <= i_cfg_data[SHIFT_W-1:0];
                REG_SHIFT_Z: r_shift[2] <= i_cfg_data[SHIFT_W-1:0];
                default: ;  // unknown index: write dropped
            endcase
        end
    end

    always_comb begin
        for (int r = 0; r < N_AXES; r++) begin
            shift_set[r] = shift_to_coord(r_shift[r]);
        end
    end

    // ---------------- stage 1: input register + empty test ----------------
    logic r_in_valid;
    t_box r_in_box;
    t_box n_in_box;
    logic mult_ready;

    assign o_box_ready = !r_in_valid || mult_ready;

    always_comb begin
        n_in_box.lo[0] = i_box_min_x;
        n_in_box.lo[1] = i_box_min_y;
        n_in_box.lo[2] = i_box_min_z;
        n_in_box.hi[0] = i_box_max_x;
        n_in_box.hi[1] = i_box_max_y;
        n_in_box.hi[2] = i_box_max_z;
        // empty if min is above max on any axis
        n_in_box.empty = (i_box_min_x > i_box_max_x) || (i_box_min_y > i_box_max_y)
                      || (i_box_min_z > i_box_max_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_box_ready) begin
            r_in_valid <= i_box_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_box_ready && i_box_valid) begin
            r_in_box <= n_in_box;
        end
    end

    // ---------------- stage 2: products ----------------
    logic   prod_valid;
    logic   bound_ready;
    t_prods prods;

    aat_mult_stage u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (mult_ready),
        .i_box   (r_in_box),
        .i_coef  (r_coef),
        .o_valid (prod_valid),
        .i_ready (bound_ready),
        .o_prods (prods)
    );

    // ---------------- stage 3: min/max select and sum ----------------
    logic  sum_valid;
    logic  round_ready;
    t_sums sums;

    aat_bound_stage u_bound (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .o_ready (bound_ready),
        .i_prods (prods),
        .i_shift (shift_set),
        .o_valid (sum_valid),
        .i_ready (round_ready),
        .o_sums  (sums)
    );

    // ---------------- stage 4: round, saturate, output register ----------------
    t_result result;

    aat_round_stage u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (sum_valid),
        .o_ready  (round_ready),
        .i_sums   (sums),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (result)
    );

    assign o_out_min_x = result.min_c[0];
    assign o_out_min_y = result.min_c[1];
    assign o_out_min_z = result.min_c[2];
    assign o_out_max_x = result.max_c[0];
    assign o_out_max_y = result.max_c[1];
    assign o_out_max_z = result.max_c[2];
    assign o_box_empty = result.empty;

    // ---------------- assertions ----------------
    // input backs up only when every stage is full and the output is stalled
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_box_ready |-> (r_in_valid && prod_valid && sum_valid && o_out_valid && !i_out_ready))
        else $error("box channel stalled with room in the pipeline");

    // a non-empty result never has min above max
    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_box_empty) |->
            (o_out_min_x <= o_out_max_x && o_out_min_y <= o_out_max_y
             && o_out_min_z <= o_out_max_z))
        else $error("transformed box has min above max");

    // empty box carries the extreme values (checked on min_x, max_x, max_y and min_z)
    a_empty_extremes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_box_empty) |->
            (o_out_min_x == COORD_MAX && o_out_max_x == COORD_MIN
             && o_out_min_z == COORD_MAX && o_out_max_y == COORD_MIN))
        else $error("empty box result lacks extreme values");

    // an accepted box reaches the product stage on the next cycle
    a_input_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && mult_ready) |=> prod_valid)
        else $error("input word lost between stage 1 and 2");

endmodule

`default_nettype wire

>>> bench/tb.sv
// tb: self-checking bench for aabb_affine_transform (box in, transformed bounds out).
// Depends on aat_pkg and the RTL under rtl/core; a scoreboard class predicts every
// output word; plain tasks drive the box and config channels, an always block the result ready.
`timescale 1ns / 100ps

import aat_pkg::*;

// Keeps a copy of the transform registers and a queue of expected output words.
class box_scoreboard;
    logic [CFG_DATA_W-1:0] row_regs [N_AXES];
    logic [SHIFT_W-1:0]    shift_regs [N_AXES];
    t_result               expected_q [$];
    string                 axis_tag [N_AXES] = '{"x", "y", "z"};
    int                    errors;
    int                    checked;
    int                    boxes;
    int                    empties;

    // Reset state: identity rows, zero shift
    function new();
        for (int r = 0; r < N_AXES; r++) begin
            row_regs[r] = '0;
            row_regs[r][r*LANE_W +: COEFF_W] = COEFF_ONE;
            shift_regs[r] = '0;
        end
    endfunction

    // Spare indexes fall to default and leave the registers alone
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ROW_X, REG_ROW_Y, REG_ROW_Z: row_regs[idx] = data;
            REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z: begin
                shift_regs[idx - REG_SHIFT_X] = data[SHIFT_W-1:0];
            end
            default: ;
        endcase
    endfunction

    // One output bound. The sum is exact in 2^-28 units, then rounded half up
    // to Q16.16 and clamped.
    function t_coord bound(int r, t_box b, bit want_max);
        t_coord sh;
        t_coord lo_v;
        t_coord hi_v;
        t_coeff c;
        longint acc;
        longint p_lo;
        longint p_hi;
        sh  = shift_regs[r];
        acc = longint'(sh) <<< COEFF_FRAC;
        for (int a = 0; a < N_AXES; a++) begin
            c    = row_regs[r][a*LANE_W +: COEFF_W];
            lo_v = b.lo[a];
            hi_v = b.hi[a];
            p_lo = longint'(c) * longint'(lo_v);
            p_hi = longint'(c) * longint'(hi_v);
            if (want_max)
                acc += (p_lo > p_hi) ? p_lo : p_hi;
            else
                acc += (p_lo < p_hi) ? p_lo : p_hi;
        end
        acc = (acc + (longint'(1) <<< (COEFF_FRAC - 1))) >>> COEFF_FRAC;
        if (acc > longint'(COORD_MAX)) return COORD_MAX;
        if (acc < longint'(COORD_MIN)) return COORD_MIN;
        return t_coord'(acc);
    endfunction

    function void note_box(t_box b);
        t_result e;
        t_coord  lo_v;
        t_coord  hi_v;
        bit      hollow;
        hollow = 1'b0;
        for (int a = 0; a < N_AXES; a++) begin
            lo_v = b.lo[a];
            hi_v = b.hi[a];
            if (lo_v > hi_v) hollow = 1'b1;
        end
        e.empty = hollow;
        for (int r = 0; r < N_AXES; r++) begin
            e.min_c[r] = hollow ? COORD_MAX : bound(r, b, 1'b0);
            e.max_c[r] = hollow ? COORD_MIN : bound(r, b, 1'b1);
        end
        expected_q.push_back(e);
        boxes++;
        if (hollow) empties++;
    endfunction

    function void check_result(t_result got);
        t_result want;
        t_coord  w;
        t_coord  g;
        if (expected_q.size() == 0) begin
            $error("result word with no box pending");
            errors++;
            return;
        end
        want = expected_q.pop_front();
        checked++;
        for (int r = 0; r < N_AXES; r++) begin
            w = want.min_c[r];
            g = got.min_c[r];
            if (g !== w) begin
                $error("out_min_%s: expected %0d, got %0d", axis_tag[r], w, g);
                errors++;
            end
            w = want.max_c[r];
            g = got.max_c[r];
            if (g !== w) begin
                $error("out_max_%s: expected %0d, got %0d", axis_tag[r], w, g);
                errors++;
            end
        end
        if (got.empty !== want.empty) begin
            $error("box_empty: expected %0d, got %0d", want.empty, got.empty);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;      // pipeline is 4 deep
    localparam int PHASES        = 8;
    localparam int PHASE_BOXES   = 250;

    // Indexes with no register behind them; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam t_coeff COEFF_TOP    = {1'b0, {(COEFF_W-1){1'b1}}};
    localparam t_coeff COEFF_BOTTOM = {1'b1, {(COEFF_W-1){1'b0}}};
    localparam t_coeff COEFF_LSB    = 1;

    // Flavors of transform loaded between random phases
    typedef enum int {
        SET_RANDOM,
        SET_TOP,          // all coefficients and shifts at their maximum
        SET_BOTTOM,       // all at their minimum
        SET_ZERO_LINEAR,  // pure translation
        SET_SWAP_NEG      // negated axis permutation, small shifts
    } t_setting;

    localparam t_setting PLAN [PHASES] = '{SET_RANDOM, SET_TOP, SET_RANDOM, SET_BOTTOM,
                                           SET_ZERO_LINEAR, SET_RANDOM, SET_SWAP_NEG,
                                           SET_RANDOM};

    logic   i_clk;
    logic   i_rst_n;
    logic   i_box_valid;
    logic   o_box_ready;
    t_coord i_box_min_x;
    t_coord i_box_min_y;
    t_coord i_box_min_z;
    t_coord i_box_max_x;
    t_coord i_box_max_y;
    t_coord i_box_max_z;
    logic   o_out_valid;
    logic   i_out_ready;
    t_coord o_out_min_x;
    t_coord o_out_min_y;
    t_coord o_out_min_z;
    t_coord o_out_max_x;
    t_coord o_out_max_y;
    t_coord o_out_max_z;
    logic   o_box_empty;
    logic   i_cfg_valid;
    logic   o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    box_scoreboard bounds_sb;
    int send_idle_pct;     // chance in percent that the sender holds off a cycle
    int stall_pct;         // chance in percent that the receiver stalls a cycle
    int cycle_count;
    int cfg_writes;
    int settings_used;

    aabb_affine_transform dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box_valid (i_box_valid),
        .o_box_ready (o_box_ready),
        .i_box_min_x (i_box_min_x),
        .i_box_min_y (i_box_min_y),
        .i_box_min_z (i_box_min_z),
        .i_box_max_x (i_box_max_x),
        .i_box_max_y (i_box_max_y),
        .i_box_max_z (i_box_max_z),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_min_x (o_out_min_x),
        .o_out_min_y (o_out_min_y),
        .o_out_min_z (o_out_min_z),
        .o_out_max_x (o_out_max_x),
        .o_out_max_y (o_out_max_y),
        .o_out_max_z (o_out_max_z),
        .o_box_empty (o_box_empty),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Receiver: ready is re-rolled every falling edge
    always @(negedge i_clk) begin
        if (i_rst_n)
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Monitor: everything is sampled at the rising edge, before the block updates.
    // Config is mirrored here too so the predictor sees exactly what was written.
    always @(posedge i_clk) begin : monitor
        t_box    seen_box;
        t_result seen_res;
        if (i_rst_n) begin
            if (i_box_valid && o_box_ready) begin
                seen_box.lo[0] = i_box_min_x;
                seen_box.lo[1] = i_box_min_y;
                seen_box.lo[2] = i_box_min_z;
                seen_box.hi[0] = i_box_max_x;
                seen_box.hi[1] = i_box_max_y;
                seen_box.hi[2] = i_box_max_z;
                seen_box.empty = 1'b0;
                bounds_sb.note_box(seen_box);
            end
            if (o_out_valid && i_out_ready) begin
                seen_res.min_c[0] = o_out_min_x;
                seen_res.min_c[1] = o_out_min_y;
                seen_res.min_c[2] = o_out_min_z;
                seen_res.max_c[0] = o_out_max_x;
                seen_res.max_c[1] = o_out_max_y;
                seen_res.max_c[2] = o_out_max_z;
                seen_res.empty    = o_box_empty;
                bounds_sb.check_result(seen_res);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                bounds_sb.write_reg(i_cfg_index, i_cfg_data);
                cfg_writes++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic t_box mk_box(t_coord lx, t_coord ly, t_coord lz,
                                    t_coord hx, t_coord hy, t_coord hz);
        t_box b;
        b.lo[0] = lx;
        b.lo[1] = ly;
        b.lo[2] = lz;
        b.hi[0] = hx;
        b.hi[1] = hy;
        b.hi[2] = hz;
        b.empty = 1'b0;
        return b;
    endfunction

    // Random magnitude: full 32-bit word shifted down a random amount, sign kept
    function automatic t_coord rand_coord();
        t_coord raw;
        raw = $urandom;
        return raw >>> $urandom_range(0, 31);
    endfunction

    function automatic t_coeff rand_coeff();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return COEFF_TOP;
            2:       return COEFF_BOTTOM;
            3, 4, 5: return t_coeff'($urandom_range(0, 2 * COEFF_ONE)) - COEFF_ONE;
            default: return t_coeff'($urandom);
        endcase
    endfunction

    // Mostly well-formed boxes, some flat on an axis, a few empty on one axis
    function automatic t_box gen_box();
        t_box   b;
        t_coord u;
        t_coord v;
        t_coord tmp;
        int     a;
        b = '0;
        for (int k = 0; k < N_AXES; k++) begin
            u = rand_coord();
            v = rand_coord();
            if ($urandom_range(0, 99) < 8) v = u;
            if (u > v) begin
                tmp = u;
                u   = v;
                v   = tmp;
            end
            b.lo[k] = u;
            b.hi[k] = v;
        end
        if ($urandom_range(0, 99) < 7) begin
            a = $urandom_range(0, N_AXES - 1);
            u = b.lo[a];
            v = b.hi[a];
            if (u != v) begin
                b.lo[a] = v;
                b.hi[a] = u;
            end else if (v != COORD_MAX) begin
                b.lo[a] = v + 1;
            end else begin
                b.hi[a] = u - 1;
            end
        end
        return b;
    endfunction

    // Holds the word until it is taken; returns on the falling edge after that
    task automatic send_box(input t_box b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_box_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_box_valid <= 1'b1;
        i_box_min_x <= b.lo[0];
        i_box_min_y <= b.lo[1];
        i_box_min_z <= b.lo[2];
        i_box_max_x <= b.hi[0];
        i_box_max_y <= b.hi[1];
        i_box_max_z <= b.hi[2];
        do @(posedge i_clk); while (!o_box_ready);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending, let every expected word come back, then let the pipe settle
    task automatic finish_phase();
        i_box_valid <= 1'b0;
        while (bounds_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_setting(input t_setting kind);
        logic [CFG_DATA_W-1:0] word;
        t_coeff                lane;
        for (int r = 0; r < N_AXES; r++) begin
            word = '0;
            for (int a = 0; a < N_AXES; a++) begin
                case (kind)
                    SET_TOP:         lane = COEFF_TOP;
                    SET_BOTTOM:      lane = COEFF_BOTTOM;
                    SET_ZERO_LINEAR: lane = '0;
                    SET_SWAP_NEG:    lane = (a == (r + 1) % N_AXES) ? -COEFF_ONE : '0;
                    default:         lane = rand_coeff();
                endcase
                word[a*LANE_W +: COEFF_W] = lane;
            end
            write_cfg(CFG_IDX_W'(REG_ROW_X + r), word);
        end
        for (int r = 0; r < N_AXES; r++) begin
            // upper 16 bits are junk the register must drop
            word = CFG_DATA_W'({$urandom, $urandom});
            case (kind)
                SET_TOP:      word[SHIFT_W-1:0] = COORD_MAX;
                SET_BOTTOM:   word[SHIFT_W-1:0] = COORD_MIN;
                SET_SWAP_NEG: word[SHIFT_W-1:0] = t_coord'($urandom) >>> 12;
                default: ;
            endcase
            write_cfg(CFG_IDX_W'(REG_SHIFT_X + r), word);
        end
        write_cfg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                  CFG_DATA_W'({$urandom, $urandom}));
        settings_used++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_idle_pct = 77; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 77; end
            3:       begin send_idle_pct = 19; stall_pct = 19; end
            default: begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_box_valid   = 1'b0;
        i_box_min_x   = '0;
        i_box_min_y   = '0;
        i_box_min_z   = '0;
        i_box_max_x   = '0;
        i_box_max_y   = '0;
        i_box_max_z   = '0;
        i_out_ready   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_ROW_X;
        i_cfg_data    = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        cycle_count   = 0;
        cfg_writes    = 0;
        settings_used = 0;
        bounds_sb     = new();

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset transform (identity): output must equal input exactly for non-empty boxes
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        // empty on a single axis, then on all three with the corners fully swapped
        send_box(mk_box(1, 0, 0, 0, 0, 0));
        send_box(mk_box(0, 65536, 0, 0, -65536, 0));
        send_box(mk_box(-5, -5, COORD_MAX, 5, 5, COORD_MIN));
        send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
        // flat box on y is valid, not empty
        send_box(mk_box(-100, 12345, -7, 100, 12345, 7));
        send_box(mk_box(-196608, -65536, -32768, 327680, 65536, 98304));
        finish_phase();

        // Directed, hand-built transform:
        //   x uses the smallest coefficient, so coordinates near 2^11 hit the
        //   round-half-up boundary; y is all max with max shift; z all min with
        //   min shift, so extreme corners saturate both ways.
        write_cfg(REG_ROW_X, {{(2*LANE_W){1'b0}}, COEFF_LSB});
        write_cfg(REG_ROW_Y, {COEFF_TOP, COEFF_TOP, COEFF_TOP});
        write_cfg(REG_ROW_Z, {COEFF_BOTTOM, COEFF_BOTTOM, COEFF_BOTTOM});
        write_cfg(REG_SHIFT_X, '0);
        write_cfg(REG_SHIFT_Y, {16'hABCD, COORD_MAX});
        write_cfg(REG_SHIFT_Z, {16'h5A5A, COORD_MIN});
        write_cfg(REG_SPARE_A, CFG_DATA_W'({$urandom, $urandom}));
        write_cfg(REG_SPARE_B, CFG_DATA_W'({$urandom, $urandom}));
        settings_used++;
        send_box(mk_box(2047, 0, 0, 2048, 0, 0));
        send_box(mk_box(-2049, 0, 0, -2048, 0, 0));
        send_box(mk_box(-6144, 0, 0, 6144, 0, 0));
        send_box(mk_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
        send_box(mk_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        finish_phase();

        // Random phases: each loads a transform, then streams boxes under one
        // idling mode (none, sender gaps, receiver stalls, both)
        for (int p = 0; p < PHASES; p++) begin
            apply_setting(PLAN[p]);
            set_idling(p % 4);
            repeat (PHASE_BOXES) send_box(gen_box());
            finish_phase();
        end

        $display("Checked %0d output words for %0d boxes (%0d empty) under %0d transforms.",
                 bounds_sb.checked, bounds_sb.boxes, bounds_sb.empties, settings_used);
        $display("%0d register writes incl. spare indexes; all four idling modes exercised.",
                 cfg_writes);
        if (bounds_sb.errors == 0 && bounds_sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
